FILE: hw/rtl/dde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dde_pkg
// Shared types, fixed-point constants and the twiddle table generator for
// the direct DFT engine.
// ----------------------------------------------------------------------------
package dde_pkg;

    // Twiddle values are Q1.15 in [-32768, 32768], so they need 17 bits.
    localparam int TW_W = 17;
    typedef logic signed [TW_W-1:0] t_tw;

    // Result fields
    localparam int BIN_W       = 24;
    localparam int BIN_INDEX_W = 6;
    localparam int BIN_MAX     = 8388607;
    localparam int BIN_MIN     = -8388608;
    localparam int ROUND_HALF  = 16384;
    localparam int FRAC_SHIFT  = 15;

    // Configuration register
    localparam int               CFG_W     = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;

    // Q2.30 constants for the table generator
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Taylor term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
    localparam logic [63:0] SIN_DIV [12] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam logic [63:0] COS_DIV [12] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // Q2.30 to Q1.15, round half up, negatives clamp to zero
    function automatic logic [TW_W-1:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v < 64'sd0) ? 64'sd0 : v;
        t = (t + 64'sd16384) >>> 15;
        return t[TW_W-1:0];
    endfunction

    // Sine and cosine of x (Q2.30, first quadrant), packed as {sin, cos}.
    // Evaluated at elaboration only.
    function automatic logic [2*TW_W-1:0] quarter_sincos(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        int                 n;
        x2 = (x * x) >> 30;
        ts = x;
        tc = ONE_Q30;
        ss = signed'(x);
        cs = signed'(ONE_Q30);
        for (n = 0; n < 12; n++) begin
            ts = ((ts * x2) >> 30) / SIN_DIV[n];
            tc = ((tc * x2) >> 30) / COS_DIV[n];
            if ((n % 2) == 0) begin
                ss = ss - signed'(ts);
                cs = cs - signed'(tc);
            end else begin
                ss = ss + signed'(ts);
                cs = cs + signed'(tc);
            end
        end
        return {q30_to_q15(ss), q30_to_q15(cs)};
    endfunction

endpackage

FILE: hw/rtl/dde_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/dde_twiddle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dde_twiddle
// Cosine/sine lookup over a full turn of MAX_POINTS steps, built from a
// quarter-wave table and quadrant symmetry. Registered output.
// ----------------------------------------------------------------------------
module dde_twiddle #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_idx,
    output dde_pkg::t_tw                  o_cos,
    output dde_pkg::t_tw                  o_sin
);
    import dde_pkg::*;

    localparam int LOG2   = $clog2(MAX_POINTS);
    localparam int QDEPTH = (MAX_POINTS >= 4) ? MAX_POINTS / 4 : 1;
    localparam int QW     = (LOG2 > 2) ? LOG2 - 2 : 1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [TW_W-1:0] w_qsin [QDEPTH];
    logic [TW_W-1:0] w_qcos [QDEPTH];

    // Quarter-wave table, entry j holds angle (pi/2) * 4j / MAX_POINTS
    for (genvar g = 0; g < QDEPTH; g++) begin : g_tab
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(4 * g)) / 64'(MAX_POINTS);
        localparam logic [2*TW_W-1:0] SC = quarter_sincos(X);
        assign w_qsin[g] = SC[2*TW_W-1:TW_W];
        assign w_qcos[g] = SC[TW_W-1:0];
    end

    logic [LOG2+1:0] w_p;
    logic [1:0]      w_quad;
    logic [QW-1:0]   w_j;
    t_tw             w_s;
    t_tw             w_c;
    t_tw             n_cos;
    t_tw             n_sin;
    t_tw             r_cos;
    t_tw             r_sin;

    assign w_p    = {i_idx, 2'b00};
    assign w_quad = w_p[LOG2+1:LOG2];
    assign w_j    = QW'(w_p[LOG2-1:0] >> 2);
    assign w_s    = signed'(w_qsin[w_j]);
    assign w_c    = signed'(w_qcos[w_j]);

    always_comb begin
        case (w_quad)
            QUAD_0: begin
                n_cos = w_c;
                n_sin = w_s;
            end
            QUAD_1: begin
                n_cos = -w_s;
                n_sin = w_c;
            end
            QUAD_2: begin
                n_cos = -w_c;
                n_sin = -w_s;
            end
            QUAD_3: begin
                n_cos = w_s;
                n_sin = -w_c;
            end
            default: begin
                n_cos = w_c;
                n_sin = w_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

FILE: hw/rtl/direct_dft_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_dft_engine
// Direct O(N^2) DFT on Q1.15 complex samples with one shared complex MAC.
// ----------------------------------------------------------------------------
// Usage: write length_log2 (1..log2(MAX_POINTS), clamped outside that range;
// a write also drops any partly loaded block), then stream N = 2^length_log2
// sample items. Each item is taken in one cycle while the block is loading.
// After the N-th item the input stalls and the engine computes bins
// k = 0..N-1, each as sum_n x[n] * exp(-j*2*pi*k*n/N), one complex product
// per cycle through a single complex multiply-accumulate fed by the sample
// RAM read port and the twiddle table. The input stays stalled until all N*N
// products of the block have been issued; the pipeline then drains while the
// next block loads. Output back-pressure freezes the whole MAC pipeline. Bins
// leave in ascending k, 15 fractional bits, rounded half up and saturated
// to 24 bits; the last bin has final_bin set. No clearing pass after reset:
// the sample RAM is only read after a full block has been written.
// ----------------------------------------------------------------------------
module direct_dft_engine #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample items
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_imag,
    // bin items
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [dde_pkg::BIN_W-1:0]       o_bin_real,
    output logic signed [dde_pkg::BIN_W-1:0]       o_bin_imag,
    output logic [dde_pkg::BIN_INDEX_W-1:0]        o_bin_index,
    output logic                                   o_final_bin,
    // length register
    input  logic                                   i_cfg_we,
    input  logic [dde_pkg::CFG_W-1:0]              i_cfg_wdata
);
    import dde_pkg::*;

    localparam int LOG2 = $clog2(MAX_POINTS);
    localparam int LGW  = $clog2(LOG2 + 1);
    localparam int SW   = SAMPLE_BITS;
    localparam int PW   = SW + TW_W;           // one real product
    localparam int SUMW = PW + 1;              // two products combined
    localparam int ACW  = SUMW + LOG2 + 1;     // N sums plus rounding headroom

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    // Per-product tag that rides along the MAC pipeline
    typedef struct packed {
        logic            valid;
        logic            first;   // n == 0
        logic            last;    // n == N-1
        logic            fin;     // k == N-1
        logic [LOG2-1:0] k;
    } t_tag;

    // ------------------------------------------------------------------
    // Length decode
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_length_log2;
    logic [LGW-1:0]   w_lg;
    logic [LOG2:0]    w_n_pts;
    logic [LOG2:0]    w_n_pts_m1;
    logic [LOG2-1:0]  w_last_idx;
    logic [LOG2-1:0]  w_stride;

    always_comb begin
        if (r_length_log2 < CFG_W'(1)) begin
            w_lg = LGW'(1);
        end else if (32'(r_length_log2) > LOG2) begin
            w_lg = LGW'(LOG2);
        end else begin
            w_lg = LGW'(r_length_log2);
        end
    end

    assign w_n_pts    = (LOG2 + 1)'(1) << w_lg;
    assign w_n_pts_m1 = w_n_pts - (LOG2 + 1)'(1);
    assign w_last_idx = w_n_pts_m1[LOG2-1:0];
    // twiddle step per unit of k*n, in table steps
    assign w_stride   = LOG2'(MAX_POINTS >> w_lg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state          r_state,    n_state;
    logic [LOG2-1:0] r_load_cnt, n_load_cnt;
    logic [LOG2-1:0] r_k,        n_k;
    logic [LOG2-1:0] r_n,        n_n;
    logic [LOG2-1:0] r_phase,    n_phase;   // k*n*stride mod MAX_POINTS
    logic [LOG2-1:0] r_step,     n_step;    // k*stride mod MAX_POINTS

    logic w_adv;      // pipeline moves this cycle
    logic w_in_acc;
    logic w_issue;

    assign o_in_stall = (r_state != ST_LOAD);
    assign w_in_acc   = i_in_valid && (r_state == ST_LOAD);
    assign w_issue    = (r_state == ST_CALC) && w_adv;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_k        = r_k;
        n_n        = r_n;
        n_phase    = r_phase;
        n_step     = r_step;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (r_load_cnt == w_last_idx) begin
                        n_state    = ST_CALC;
                        n_load_cnt = '0;
                        n_k        = '0;
                        n_n        = '0;
                        n_phase    = '0;
                        n_step     = '0;
                    end else begin
                        n_load_cnt = r_load_cnt + LOG2'(1);
                    end
                end
            end
            ST_CALC: begin
                if (w_issue) begin
                    if (r_n == w_last_idx) begin
                        n_n     = '0;
                        n_phase = '0;
                        if (r_k == w_last_idx) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_k    = r_k + LOG2'(1);
                            n_step = r_step + w_stride;
                        end
                    end else begin
                        n_n     = r_n + LOG2'(1);
                        n_phase = r_phase + r_step;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        // a length write drops a partial block
        if (i_cfg_we) begin
            n_load_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_load_cnt    <= '0;
            r_k           <= '0;
            r_n           <= '0;
            r_phase       <= '0;
            r_step        <= '0;
            r_length_log2 <= CFG_RESET;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_k        <= n_k;
            r_n        <= n_n;
            r_phase    <= n_phase;
            r_step     <= n_step;
            if (i_cfg_we) begin
                r_length_log2 <= i_cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample store and twiddle lookup (stage 1)
    // ------------------------------------------------------------------
    logic [2*SW-1:0] w_ram_q;
    t_tw             w_tw_cos;
    t_tw             w_tw_sin;

    dde_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_load_cnt),
        .i_wdata ({i_sample_real, i_sample_imag}),
        .i_re    (w_issue),
        .i_raddr (r_n),
        .o_rdata (w_ram_q)
    );

    dde_twiddle #(
        .MAX_POINTS (MAX_POINTS)
    ) u_twiddle (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_idx (r_phase),
        .o_cos (w_tw_cos),
        .o_sin (w_tw_sin)
    );

    // ------------------------------------------------------------------
    // MAC pipeline: products (2), sums (3), accumulate (4), round (out)
    // ------------------------------------------------------------------
    t_tag w_tag0;
    t_tag w_tag4;
    t_tag r_s1, r_s2, r_s3, r_s4;

    logic signed [SW-1:0]   w_xr;
    logic signed [SW-1:0]   w_xi;
    logic signed [PW-1:0]   r_prc, r_pis, r_pic, r_prs;
    logic signed [SUMW-1:0] r_sum_r, r_sum_i;
    logic signed [ACW-1:0]  r_acc_r, r_acc_i;

    assign w_tag0.valid = w_issue;
    assign w_tag0.first = (r_n == '0);
    assign w_tag0.last  = (r_n == w_last_idx);
    assign w_tag0.fin   = (r_k == w_last_idx);
    assign w_tag0.k     = r_k;

    // stage 4 marks a finished bin in the accumulator
    always_comb begin
        w_tag4       = r_s3;
        w_tag4.valid = r_s3.valid && r_s3.last;
    end

    assign w_xr = signed'(w_ram_q[2*SW-1:SW]);
    assign w_xi = signed'(w_ram_q[SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (w_adv) begin
            r_s1 <= w_tag0;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= w_tag4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prc   <= w_xr * w_tw_cos;
            r_pis   <= w_xi * w_tw_sin;
            r_pic   <= w_xi * w_tw_cos;
            r_prs   <= w_xr * w_tw_sin;
            r_sum_r <= SUMW'(r_prc) + SUMW'(r_pis);
            r_sum_i <= SUMW'(r_pic) - SUMW'(r_prs);
            if (r_s3.valid) begin
                if (r_s3.first) begin
                    r_acc_r <= ACW'(r_sum_r);
                    r_acc_i <= ACW'(r_sum_i);
                end else begin
                    r_acc_r <= r_acc_r + ACW'(r_sum_r);
                    r_acc_i <= r_acc_i + ACW'(r_sum_i);
                end
            end
        end
    end

    // Round half up (floor of (acc + 2^14) / 2^15), then saturate
    logic signed [ACW-1:0]   w_rnd_r, w_rnd_i;
    logic signed [BIN_W-1:0] w_bin_r, w_bin_i;

    assign w_rnd_r = (r_acc_r + ACW'(ROUND_HALF)) >>> FRAC_SHIFT;
    assign w_rnd_i = (r_acc_i + ACW'(ROUND_HALF)) >>> FRAC_SHIFT;

    always_comb begin
        if (w_rnd_r > ACW'(BIN_MAX)) begin
            w_bin_r = BIN_W'(BIN_MAX);
        end else if (w_rnd_r < ACW'(BIN_MIN)) begin
            w_bin_r = BIN_W'(BIN_MIN);
        end else begin
            w_bin_r = w_rnd_r[BIN_W-1:0];
        end
        if (w_rnd_i > ACW'(BIN_MAX)) begin
            w_bin_i = BIN_W'(BIN_MAX);
        end else if (w_rnd_i < ACW'(BIN_MIN)) begin
            w_bin_i = BIN_W'(BIN_MIN);
        end else begin
            w_bin_i = w_rnd_i[BIN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register; a held result freezes the MAC pipeline
    // ------------------------------------------------------------------
    logic                    r_out_valid;
    logic signed [BIN_W-1:0] r_bin_real, r_bin_imag;
    logic [BIN_INDEX_W-1:0]  r_bin_index;
    logic                    r_final_bin;

    assign w_adv = !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s4.valid) begin
            r_bin_real  <= w_bin_r;
            r_bin_imag  <= w_bin_i;
            r_bin_index <= BIN_INDEX_W'(r_s4.k);
            r_final_bin <= r_s4.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_real  = r_bin_real;
    assign o_bin_imag  = r_bin_imag;
    assign o_bin_index = r_bin_index;
    assign o_final_bin = r_final_bin;

endmodule

FILE: hw/rtl/dde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dde_checker
// Port-level checks for the direct DFT engine, bound to the top level.
// ----------------------------------------------------------------------------
module dde_checker #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic signed [SAMPLE_BITS-1:0]     i_sample_real,
    input logic signed [SAMPLE_BITS-1:0]     i_sample_imag,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [dde_pkg::BIN_W-1:0]  o_bin_real,
    input logic signed [dde_pkg::BIN_W-1:0]  o_bin_imag,
    input logic [dde_pkg::BIN_INDEX_W-1:0]   o_bin_index,
    input logic                              o_final_bin,
    input logic                              i_cfg_we,
    input logic [dde_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import dde_pkg::*;

    localparam int LOG2 = $clog2(MAX_POINTS);
    localparam int LGW  = $clog2(LOG2 + 1);

    logic [CFG_W-1:0]       r_len;
    logic [LGW-1:0]         w_lg;
    logic [LOG2:0]          w_n_m1;
    logic [LOG2:0]          r_loads;
    logic [BIN_INDEX_W-1:0] r_exp_idx;
    logic                   w_in_acc;
    logic                   w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        if (r_len < CFG_W'(1)) begin
            w_lg = LGW'(1);
        end else if (32'(r_len) > LOG2) begin
            w_lg = LGW'(LOG2);
        end else begin
            w_lg = LGW'(r_len);
        end
    end

    assign w_n_m1 = ((LOG2 + 1)'(1) << w_lg) - (LOG2 + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= CFG_RESET;
            r_loads   <= '0;
            r_exp_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len   <= i_cfg_wdata;
                r_loads <= '0;
            end else if (w_in_acc) begin
                r_loads <= (r_loads == w_n_m1) ? '0 : r_loads + (LOG2 + 1)'(1);
            end
            if (w_out_acc) begin
                r_exp_idx <= o_final_bin ? '0 : r_exp_idx + BIN_INDEX_W'(1);
            end
        end
    end

    // bins come out in ascending order, restarting after the last one
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bin_index == r_exp_idx)
        else $error("bin index out of order");

    // the last bin carries index N-1
    a_final_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_final_bin |-> o_bin_index == BIN_INDEX_W'(w_n_m1))
        else $error("final bin at wrong index");

    // a completed block stops the input while bins are computed
    a_block_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_cfg_we && r_loads == w_n_m1 |=> o_in_stall)
        else $error("input not stalled after full block");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bin_real)
            && $stable(o_bin_imag) && $stable(o_bin_index) && $stable(o_final_bin))
        else $error("stalled result changed");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_sample_real)
            && $stable(i_sample_imag))
        else $error("stalled input item changed");

endmodule

bind direct_dft_engine dde_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dde_checker (.*);

FILE: tb/sv/direct_dft_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_dft_engine_tb
// Self-checking bench for the direct DFT engine. A driver streams sample
// items from a queue, a monitor predicts every bin from its own twiddle table
// and sample store, and each bin leaving the block is checked in order.
// Both handshakes idle in random bursts; the length register is swept across
// every code, including the clamped ones.
// ----------------------------------------------------------------------------
module direct_dft_engine_tb;

    import dde_pkg::*;

    localparam int  MAX_PTS     = 64;
    localparam int  MAX_LOG2    = 6;
    localparam int  SMP_W       = 16;
    localparam int  ITEM_TARGET = 460;
    localparam int  QUIET_AT    = 400;  // idling stops past this many items
    localparam int  SETTLE      = 16;   // pipeline flush before a register write
    localparam int  TAIL_CYCLES = 64;
    localparam int  TIMEOUT_NS  = 4000000;

    typedef struct {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_sample;

    typedef struct {
        logic signed [BIN_W-1:0]       re;
        logic signed [BIN_W-1:0]       im;
        logic [BIN_INDEX_W-1:0]        idx;
        logic                          last;
    } t_bin;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic signed [SMP_W-1:0]        i_sample_real;
    logic signed [SMP_W-1:0]        i_sample_imag;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic signed [BIN_W-1:0]        o_bin_real;
    logic signed [BIN_W-1:0]        o_bin_imag;
    logic [BIN_INDEX_W-1:0]         o_bin_index;
    logic                           o_final_bin;
    logic                           i_cfg_we;
    logic [CFG_W-1:0]               i_cfg_wdata;

    direct_dft_engine #(
        .MAX_POINTS  (MAX_PTS),
        .SAMPLE_BITS (SMP_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bin_real    (o_bin_real),
        .o_bin_imag    (o_bin_imag),
        .o_bin_index   (o_bin_index),
        .o_final_bin   (o_final_bin),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_sample    sample_q[$];        // items waiting for the driver
    t_bin       bins_due[$];        // predicted bins, oldest first
    t_sample    next_smp;
    logic       in_taken;           // input handshake fired at the last edge
    int         send_gap;
    int         stall_left;
    int         in_idle_pct;
    int         out_idle_pct;
    int         err_count;
    int         items_pushed;
    int         items_taken;
    int         bins_checked;
    int         blocks_done;
    logic [7:0] codes_written;
    logic [MAX_LOG2:0] lengths_done;

    // Predictor state: its own copy of the length register and sample store
    logic [CFG_W-1:0] cur_lg;
    int               fill_count;
    int               store_re [MAX_PTS];
    int               store_im [MAX_PTS];
    longint           tw_cos   [MAX_PTS];
    longint           tw_sin   [MAX_PTS];

    // ------------------------------------------------------------------------
    // Twiddle table: first-quadrant Taylor series in Q2.30, rounded half up
    // to Q1.15, then folded into the other quadrants.
    // ------------------------------------------------------------------------
    function automatic longint q15_round(input longint v);
        longint t;
        t = (v < 0) ? 0 : v;
        return (t + ROUND_HALF) >>> FRAC_SHIFT;
    endfunction

    function automatic void build_twiddles();
        longint unsigned x, x2, ts, tc, r, q;
        longint          ss, cs, s15, c15;
        for (int i = 0; i < MAX_PTS; i++) begin
            q  = (4 * i) / MAX_PTS;
            r  = (4 * i) % MAX_PTS;
            x  = (longint'(HALF_PI_Q30) * r) / MAX_PTS;
            x2 = (x * x) >> 30;
            ts = x;
            tc = longint'(ONE_Q30);
            ss = longint'(x);
            cs = longint'(ONE_Q30);
            for (int n = 1; n <= 12; n++) begin
                ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                if (n % 2) begin
                    ss -= longint'(ts);
                    cs -= longint'(tc);
                end else begin
                    ss += longint'(ts);
                    cs += longint'(tc);
                end
            end
            s15 = q15_round(ss);
            c15 = q15_round(cs);
            case (q % 4)
                0: begin tw_cos[i] = c15;  tw_sin[i] = s15;  end
                1: begin tw_cos[i] = -s15; tw_sin[i] = c15;  end
                2: begin tw_cos[i] = -c15; tw_sin[i] = -s15; end
                default: begin tw_cos[i] = s15; tw_sin[i] = -c15; end
            endcase
        end
    endfunction

    // Register codes 0 and 7 clamp to the nearest legal length
    function automatic int active_log2(input logic [CFG_W-1:0] code);
        if (code < 1)        return 1;
        if (code > MAX_LOG2) return MAX_LOG2;
        return int'(code);
    endfunction

    // Round half up (floor of (acc + 2^14) / 2^15), then saturate to 24 bits
    function automatic logic signed [BIN_W-1:0] bin_round(input longint acc);
        longint r;
        r = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (r > BIN_MAX) r = BIN_MAX;
        if (r < BIN_MIN) r = BIN_MIN;
        return r[BIN_W-1:0];
    endfunction

    // Store one sample; the N-th one of a block queues all N bins
    task automatic take_sample(input logic signed [SMP_W-1:0] re,
                               input logic signed [SMP_W-1:0] im);
        int     lg, n_pts, stride, ti;
        longint acc_re, acc_im, xr, xi;
        t_bin   b;
        lg     = active_log2(cur_lg);
        n_pts  = 1 << lg;
        stride = MAX_PTS >> lg;
        if (fill_count >= n_pts) fill_count = 0;
        store_re[fill_count] = re;
        store_im[fill_count] = im;
        fill_count++;
        if (fill_count < n_pts) return;
        fill_count = 0;
        for (int k = 0; k < n_pts; k++) begin
            acc_re = 0;
            acc_im = 0;
            for (int n = 0; n < n_pts; n++) begin
                ti = (((k * n) & (n_pts - 1)) * stride) & (MAX_PTS - 1);
                xr = store_re[n];
                xi = store_im[n];
                acc_re += xr * tw_cos[ti] + xi * tw_sin[ti];
                acc_im += xi * tw_cos[ti] - xr * tw_sin[ti];
            end
            b.re   = bin_round(acc_re);
            b.im   = bin_round(acc_im);
            b.idx  = k[BIN_INDEX_W-1:0];
            b.last = (k == n_pts - 1);
            bins_due.insert(bins_due.size(), b);
        end
        blocks_done++;
        lengths_done[lg] = 1'b1;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: new item at the falling edge once the last one was taken.
    // Valid is held across a stall and never drops until the handshake.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                next_smp = sample_q.pop_front();
                i_in_valid    <= 1'b1;
                i_sample_real <= next_smp.re;
                i_sample_imag <= next_smp.im;
                if ($urandom_range(99) < in_idle_pct)
                    send_gap = $urandom_range(1, 14);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < out_idle_pct) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sees register writes, accepted samples and accepted bins at
    // the rising edge. Prediction runs on the accepted sample itself.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bin b;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                // a write also drops any partly loaded block
                cur_lg     = i_cfg_wdata;
                fill_count = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                take_sample(i_sample_real, i_sample_imag);
            end
            if (o_out_valid && !i_out_stall) begin
                if (bins_due.size() == 0) begin
                    $error("unexpected bin: index %0d, real %0d, imag %0d",
                           o_bin_index, o_bin_real, o_bin_imag);
                    err_count++;
                end else begin
                    b = bins_due.pop_front();
                    check_field("bin_real",  b.re,   o_bin_real);
                    check_field("bin_imag",  b.im,   o_bin_imag);
                    check_field("bin_index", b.idx,  o_bin_index);
                    check_field("final_bin", b.last, o_final_bin);
                    bins_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_sample(input int re, input int im);
        t_sample s;
        s.re = re[SMP_W-1:0];
        s.im = im[SMP_W-1:0];
        sample_q.insert(sample_q.size(), s);
        items_pushed++;
    endtask

    // Full-scale corners often, otherwise any 16-bit value
    function automatic int rand_sample();
        case ($urandom_range(7))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    // Sender holds off until the queue is empty, nothing is in flight and
    // every predicted bin has arrived; then the pipeline gets time to flush.
    task automatic wait_drained();
        while (sample_q.size() > 0 || i_in_valid || bins_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] code);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        codes_written[code] = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int lg_code, n_pts, nblk, phase, remaining;
        int pct_choice [3];

        pct_choice = '{0, 15, 40};
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sample_real = '0;
        i_sample_imag = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_taken      = 1'b0;
        send_gap      = 0;
        stall_left    = 0;
        in_idle_pct   = 20;
        out_idle_pct  = 20;
        err_count     = 0;
        items_pushed  = 0;
        items_taken   = 0;
        bins_checked  = 0;
        blocks_done   = 0;
        codes_written = '0;
        lengths_done  = '0;
        cur_lg        = CFG_RESET;
        fill_count    = 0;
        build_twiddles();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // A few items at the reset length (64 points) must give no bins;
        // the following write then throws the partial block away.
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(12345, -4321);
        write_length(3'd1);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        // code 0 clamps to the 2-point length
        write_length(3'd0);
        push_sample(-32768, -32768);
        push_sample(32767, 32767);
        // 8 points; the sender pauses mid-block until all bins are home
        write_length(3'd3);
        push_sample(32767, 32767);
        push_sample(-32768, -32768);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        wait_drained();
        push_sample(0, 0);
        push_sample(1, -1);
        push_sample(-1, 1);
        push_sample(32767, 0);
        // 4 points of negative full scale: everything lands in bin 0
        write_length(3'd2);
        repeat (4) push_sample(-32768, -32768);

        // Random part: whole blocks with random content, now and then a
        // trailing partial block that the next register write discards.
        phase = 0;
        while (items_pushed < ITEM_TARGET) begin
            case (phase)
                0:       lg_code = 7;   // clamps to 64 points
                1:       lg_code = 6;
                2:       lg_code = 4;
                3:       lg_code = 5;
                default: lg_code = $urandom_range(0, 7);
            endcase
            // near the end, shorten the length so the budget is not overrun
            remaining = ITEM_TARGET - items_pushed;
            while (lg_code > 1 && (1 << active_log2(lg_code[CFG_W-1:0])) > remaining)
                lg_code = active_log2(lg_code[CFG_W-1:0]) - 1;
            write_length(lg_code[CFG_W-1:0]);
            if (items_pushed >= QUIET_AT) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = pct_choice[$urandom_range(0, 2)];
                out_idle_pct = pct_choice[$urandom_range(0, 2)];
            end
            n_pts = 1 << active_log2(lg_code[CFG_W-1:0]);
            nblk  = (n_pts <= 8) ? $urandom_range(1, 6) : (n_pts < 64) ? 2 : 1;
            while (nblk > 1 && nblk * n_pts > remaining)
                nblk--;
            repeat (nblk * n_pts) push_sample(rand_sample(), rand_sample());
            if ($urandom_range(3) == 0 && nblk * n_pts + n_pts <= remaining)
                repeat ($urandom_range(1, n_pts - 1))
                    push_sample(rand_sample(), rand_sample());
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d samples in %0d transforms (%0d bins checked), %0d of 6 lengths,",
                 items_taken, blocks_done, bins_checked, $countones(lengths_done));
        $display("register codes written: %b (bit per code)", codes_written);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $error("timeout: %0d bins still due, %0d items queued",
               bins_due.size(), sample_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
